// ===== rtl/ree_pkg.sv =====
// ree_pkg: shared types and constants for the ray/ellipsoid intersection block
// no dependencies; used by ray_ellipsoid_intersect_top
`default_nettype none

package ree_pkg;

  // field widths
  localparam int AXIS_W = 27;
  localparam int THR_W  = 21;
  localparam int POS_W  = 29;
  localparam int DIR_W  = 32;
  localparam int OUT_W  = 32;
  localparam int CFG_W  = 27;
  localparam int IDX_W  = 2;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_ZERO = 2'd2;

  // configuration register indexes
  typedef logic [IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_AXIS_X = 2'd0;
  localparam reg_idx_t REG_AXIS_Y = 2'd1;
  localparam reg_idx_t REG_AXIS_Z = 2'd2;
  localparam reg_idx_t REG_THRESH = 2'd3;

  // reset values of the configuration registers
  localparam logic [AXIS_W-1:0] AXIS_X_RST = 27'd102050192;
  localparam logic [AXIS_W-1:0] AXIS_Y_RST = 27'd102050192;
  localparam logic [AXIS_W-1:0] AXIS_Z_RST = 27'd101708037;
  localparam logic [THR_W-1:0]  THRESH_RST = 21'd1;

  // per-word side data that travels with the pipeline
  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][DIR_W-1:0] dir;
    status_t               st;
  } ctx_t;

endpackage

`default_nettype wire

// ===== rtl/ree_div.sv =====
// ree_div: pipelined restoring divider, one quotient bit per stage
// standalone; requires NW-QB <= DW
`default_nettype none

module ree_div #(
  parameter int NW = 59,
  parameter int DW = 28,
  parameter int QB = 31
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QB-1:0] quo,
  output logic      [DW-1:0] rem,
  output logic      [DW-1:0] den_o,
  output logic               ovf
);

  logic [DW-1:0] r_q  [0:QB];
  logic [QB-1:0] q_q  [0:QB];
  logic [QB-1:0] lo_q [0:QB];
  logic [DW-1:0] d_q  [0:QB];
  logic          ov_q [0:QB];

  // first stage: upper dividend bits and quotient overflow check
  always_ff @(posedge clk) begin
    if (en) begin
      r_q[0]  <= DW'(num[NW-1:QB]);
      lo_q[0] <= num[QB-1:0];
      d_q[0]  <= den;
      ov_q[0] <= (DW'(num[NW-1:QB]) >= den);
      q_q[0]  <= '0;
    end
  end

  // one shift-compare-subtract per stage
  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      t    = {r_q[j-1], lo_q[j-1][QB-j]};
      diff = t - {1'b0, d_q[j-1]};
      ge   = (t >= {1'b0, d_q[j-1]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[j]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        q_q[j]  <= {q_q[j-1][QB-2:0], ge};
        lo_q[j] <= lo_q[j-1];
        d_q[j]  <= d_q[j-1];
        ov_q[j] <= ov_q[j-1];
      end
    end
  end

  assign quo   = q_q[QB];
  assign rem   = r_q[QB];
  assign den_o = d_q[QB];
  assign ovf   = ov_q[QB];

endmodule

`default_nettype wire

// ===== rtl/ray_ellipsoid_intersect_top.sv =====
// ray_ellipsoid_intersect_top: ray / ellipsoid intersection pipeline
// depends on ree_pkg and ree_div
//
// Usage:
//  - input channel (in_valid/in_ready) carries one ray word: position pos_* in
//    meters*16 and look direction dir_* in Q2.30
//  - output channel (out_valid/out_ready) returns one word per ray: status,
//    slant_range and intersection point look_*
//  - configuration writes (cfg_wr_en, cfg_index, cfg_data) set the three
//    semi-axes and the zero-direction threshold; write only while idle
//  - fully pipelined: one ray per cycle unless the output stalls; the depth
//    from input accept to output valid is set by the per-axis normalizing dividers
//    (32 stages), the 63-stage square root and the 33-stage range divider
//  - when out_valid is high and out_ready low, the whole pipeline holds and
//    in_ready drops; nothing is lost or repeated
//  - reset clears all valid bits and loads the default ellipsoid and threshold
//  - status miss or zero-direction words carry zero range and point
`default_nettype none

module ray_ellipsoid_intersect_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ree_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [ree_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [ree_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [ree_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [ree_pkg::POS_W-1:0] pos_z,
  input  wire logic signed [ree_pkg::DIR_W-1:0] dir_x,
  input  wire logic signed [ree_pkg::DIR_W-1:0] dir_y,
  input  wire logic signed [ree_pkg::DIR_W-1:0] dir_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        status,
  output logic signed [ree_pkg::OUT_W-1:0]  slant_range,
  output logic signed [ree_pkg::OUT_W-1:0]  look_x,
  output logic signed [ree_pkg::OUT_W-1:0]  look_y,
  output logic signed [ree_pkg::OUT_W-1:0]  look_z
);

  // stage numbers
  localparam int NQB       = 31;
  localparam int FQB       = 32;
  localparam int SQ_BITS   = 63;
  localparam int L_IN      = 1;
  localparam int L_NUM     = 2;
  localparam int L_NDIV    = L_NUM + NQB + 1;
  localparam int L_SV      = L_NDIV + 1;
  localparam int L_PROD    = L_SV + 1;
  localparam int L_SUM     = L_PROD + 1;
  localparam int L_PART    = L_SUM + 1;
  localparam int L_PQ      = L_PART + 1;
  localparam int L_DISC    = L_PQ + 1;
  localparam int L_SQ_END  = L_DISC + SQ_BITS;
  localparam int L_T       = L_SQ_END + 1;
  localparam int L_FDIV    = L_T + FQB + 1;
  localparam int L_D       = L_FDIV + 1;
  localparam int L_LP      = L_D + 1;
  localparam int LAT       = L_LP + 1;

  // configuration registers
  logic [ree_pkg::AXIS_W-1:0] axis [3];
  logic [ree_pkg::THR_W-1:0]  thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis[0] <= ree_pkg::AXIS_X_RST;
      axis[1] <= ree_pkg::AXIS_Y_RST;
      axis[2] <= ree_pkg::AXIS_Z_RST;
      thresh  <= ree_pkg::THRESH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ree_pkg::REG_AXIS_X: axis[0] <= cfg_data;
        ree_pkg::REG_AXIS_Y: axis[1] <= cfg_data;
        ree_pkg::REG_AXIS_Z: axis[2] <= cfg_data;
        ree_pkg::REG_THRESH: thresh  <= cfg_data[ree_pkg::THR_W-1:0];
      endcase
    end
  end

  // global advance and valid bits
  logic           en;
  logic [LAT:1]   vld;

  assign en        = !vld[LAT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  ree_pkg::ctx_t ctx [L_IN:L_LP];

  // side data passes unchanged except where status is updated
  for (genvar k = L_NUM; k <= L_LP; k++) begin : g_ctx
    if (k != L_SUM && k != L_DISC) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) ctx[k] <= ctx[k-1];
      end
    end
  end

  // input stage: zero-direction and zero-axis checks
  logic [ree_pkg::DIR_W-1:0] in_um [3];
  logic [33:0]               in_usum;
  logic                      in_zero;
  logic                      in_axis0;

  always_comb begin
    in_um[0] = dir_x[31] ? 32'(-dir_x) : 32'(dir_x);
    in_um[1] = dir_y[31] ? 32'(-dir_y) : 32'(dir_y);
    in_um[2] = dir_z[31] ? 32'(-dir_z) : 32'(dir_z);
    in_usum  = 34'(in_um[0]) + 34'(in_um[1]) + 34'(in_um[2]);
    in_zero  = (in_usum < 34'(thresh));
    in_axis0 = (axis[0] == '0) || (axis[1] == '0) || (axis[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[L_IN].pos[0] <= pos_x;
      ctx[L_IN].pos[1] <= pos_y;
      ctx[L_IN].pos[2] <= pos_z;
      ctx[L_IN].dir[0] <= dir_x;
      ctx[L_IN].dir[1] <= dir_y;
      ctx[L_IN].dir[2] <= dir_z;
      ctx[L_IN].st     <= in_zero ? ree_pkg::ST_ZERO :
                          (in_axis0 ? ree_pkg::ST_MISS : ree_pkg::ST_OK);
    end
  end

  // numerators for rounded normalization: 2*|x|*2^sh + a over 2*a
  logic [58:0] num_p [3];
  logic [58:0] num_u [3];

  for (genvar i = 0; i < 3; i++) begin : g_num
    logic signed [ree_pkg::POS_W-1:0] p;
    logic signed [ree_pkg::DIR_W-1:0] u;
    logic [28:0] pm;
    logic [31:0] um;

    always_comb begin
      p  = $signed(ctx[L_IN].pos[i]);
      u  = $signed(ctx[L_IN].dir[i]);
      pm = p[28] ? 29'(-p) : 29'(p);
      um = u[31] ? 32'(-u) : 32'(u);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_p[i] <= {1'b0, pm, 29'd0} + {32'd0, axis[i]};
        num_u[i] <= {um, 27'd0} + {32'd0, axis[i]};
      end
    end
  end

  // per-axis normalizing dividers
  logic [NQB-1:0] nq_p [3];
  logic [NQB-1:0] nq_u [3];
  logic           nov_p [3];
  logic           nov_u [3];

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    logic [27:0] rp;
    logic [27:0] ru;
    logic [27:0] dp;
    logic [27:0] du;

    ree_div #(.NW(59), .DW(28), .QB(NQB)) u_div_p (
      .clk   (clk),
      .en    (en),
      .num   (num_p[i]),
      .den   ({axis[i], 1'b0}),
      .quo   (nq_p[i]),
      .rem   (rp),
      .den_o (dp),
      .ovf   (nov_p[i])
    );

    ree_div #(.NW(59), .DW(28), .QB(NQB)) u_div_u (
      .clk   (clk),
      .en    (en),
      .num   (num_u[i]),
      .den   ({axis[i], 1'b0}),
      .quo   (nq_u[i]),
      .rem   (ru),
      .den_o (du),
      .ovf   (nov_u[i])
    );
  end

  // clamp to 2^30 and restore the sign
  logic signed [31:0] sv_s [3];
  logic signed [31:0] sv_v [3];

  for (genvar i = 0; i < 3; i++) begin : g_sv
    logic [31:0] sm;
    logic [31:0] vm;

    always_comb begin
      sm = (nov_p[i] || nq_p[i] > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, nq_p[i]};
      vm = (nov_u[i] || nq_u[i] > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, nq_u[i]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv_s[i] <= ctx[L_NDIV].pos[i][28] ? -$signed(sm) : $signed(sm);
        sv_v[i] <= ctx[L_NDIV].dir[i][31] ? -$signed(vm) : $signed(vm);
      end
    end
  end

  // products of normalized terms
  logic signed [63:0] pr_vv [3];
  logic signed [63:0] pr_sv [3];
  logic signed [63:0] pr_ss [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_vv[i] <= sv_v[i] * sv_v[i];
        pr_sv[i] <= sv_s[i] * sv_v[i];
        pr_ss[i] <= sv_s[i] * sv_s[i];
      end
    end
  end

  // quadratic coefficients A, H, C
  logic        [61:0] a_sh [L_SUM:L_SQ_END];
  logic signed [62:0] h_sh [L_SUM:L_SQ_END];
  logic signed [62:0] c_s;
  logic        [63:0] sum_a;
  logic signed [63:0] sum_h;
  logic        [63:0] sum_c;

  always_comb begin
    sum_a = 64'(pr_vv[0]) + 64'(pr_vv[1]) + 64'(pr_vv[2]);
    sum_h = pr_sv[0] + pr_sv[1] + pr_sv[2];
    sum_c = 64'(pr_ss[0]) + 64'(pr_ss[1]) + 64'(pr_ss[2]) - (64'd1 << 56);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sh[L_SUM]    <= sum_a[61:0];
      h_sh[L_SUM]    <= sum_h[62:0];
      c_s            <= $signed(sum_c[62:0]);
      ctx[L_SUM].pos <= ctx[L_PROD].pos;
      ctx[L_SUM].dir <= ctx[L_PROD].dir;
      ctx[L_SUM].st  <= (ctx[L_PROD].st == ree_pkg::ST_OK && sum_a == '0) ?
                        ree_pkg::ST_MISS : ctx[L_PROD].st;
    end
  end

  for (genvar k = L_SUM + 1; k <= L_SQ_END; k++) begin : g_coef
    always_ff @(posedge clk) begin
      if (en) begin
        a_sh[k] <= a_sh[k-1];
        h_sh[k] <= h_sh[k-1];
      end
    end
  end

  // partial products of H^2 and A*|C|
  logic [61:0] hm;
  logic [61:0] cm;
  logic [61:0] pp_hh, pp_hl, pp_ll;
  logic [61:0] qp_hh, qp_hl, qp_lh, qp_ll;
  logic        c_neg_p;

  always_comb begin
    hm = h_sh[L_SUM][62] ? 62'(-h_sh[L_SUM]) : 62'(h_sh[L_SUM]);
    cm = c_s[62] ? 62'(-c_s) : 62'(c_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh   <= hm[61:31] * hm[61:31];
      pp_hl   <= hm[61:31] * hm[30:0];
      pp_ll   <= hm[30:0] * hm[30:0];
      qp_hh   <= a_sh[L_SUM][61:31] * cm[61:31];
      qp_hl   <= a_sh[L_SUM][61:31] * cm[30:0];
      qp_lh   <= a_sh[L_SUM][30:0] * cm[61:31];
      qp_ll   <= a_sh[L_SUM][30:0] * cm[30:0];
      c_neg_p <= c_s[62];
    end
  end

  // assemble P = H^2 and Q = A*|C|
  logic [125:0] pq_p;
  logic [125:0] pq_q;
  logic         c_neg_q;

  always_ff @(posedge clk) begin
    if (en) begin
      pq_p    <= {2'd0, pp_hh, 62'd0} + {32'd0, pp_hl, 32'd0} + {64'd0, pp_ll};
      pq_q    <= {2'd0, qp_hh, 62'd0} + {33'd0, qp_hl, 31'd0} + {33'd0, qp_lh, 31'd0}
                 + {64'd0, qp_ll};
      c_neg_q <= c_neg_p;
    end
  end

  // discriminant and miss check
  logic [125:0] sq_d   [L_DISC:L_SQ_END];
  logic [64:0]  sq_rem [L_DISC:L_SQ_END];
  logic [62:0]  sq_res [L_DISC:L_SQ_END];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d[L_DISC]    <= c_neg_q ? (pq_p + pq_q) : (pq_p - pq_q);
      sq_rem[L_DISC]  <= '0;
      sq_res[L_DISC]  <= '0;
      ctx[L_DISC].pos <= ctx[L_PQ].pos;
      ctx[L_DISC].dir <= ctx[L_PQ].dir;
      ctx[L_DISC].st  <= (ctx[L_PQ].st == ree_pkg::ST_OK && !c_neg_q && pq_p < pq_q) ?
                         ree_pkg::ST_MISS : ctx[L_PQ].st;
    end
  end

  // square root, one result bit per stage
  for (genvar j = 1; j <= SQ_BITS; j++) begin : g_sqrt
    localparam int B = SQ_BITS - j;
    logic [66:0] t;
    logic [66:0] trial;
    logic [66:0] diff;
    logic        ge;

    always_comb begin
      t     = {sq_rem[L_DISC+j-1], sq_d[L_DISC+j-1][2*B+1:2*B]};
      trial = {2'd0, sq_res[L_DISC+j-1], 2'b01};
      diff  = t - trial;
      ge    = (t >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[L_DISC+j] <= ge ? diff[64:0] : t[64:0];
        sq_res[L_DISC+j] <= {sq_res[L_DISC+j-1][61:0], ge};
        sq_d[L_DISC+j]   <= sq_d[L_DISC+j-1];
      end
    end
  end

  // T = |H + R| and the sign of the range
  logic [63:0] t_val;
  logic        t_neg;
  logic [61:0] t_hm;
  logic [91:0] fd_num;
  logic [61:0] fd_den;
  logic        neg_sh [L_T:L_FDIV];

  always_comb begin
    t_hm = h_sh[L_SQ_END][62] ? 62'(-h_sh[L_SQ_END]) : 62'(h_sh[L_SQ_END]);
    if (!h_sh[L_SQ_END][62]) begin
      t_val = 64'(h_sh[L_SQ_END][61:0]) + 64'(sq_res[L_SQ_END]);
      t_neg = 1'b1;
    end else if (sq_res[L_SQ_END] >= 63'(t_hm)) begin
      t_val = 64'(sq_res[L_SQ_END]) - 64'(t_hm);
      t_neg = 1'b1;
    end else begin
      t_val = 64'(t_hm) - 64'(sq_res[L_SQ_END]);
      t_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fd_num     <= {t_val, 28'd0};
      fd_den     <= a_sh[L_SQ_END];
      neg_sh[L_T] <= t_neg;
    end
  end

  for (genvar k = L_T + 1; k <= L_FDIV; k++) begin : g_neg
    always_ff @(posedge clk) begin
      if (en) neg_sh[k] <= neg_sh[k-1];
    end
  end

  // range divider: T*2^28 / A
  logic [FQB-1:0] fq;
  logic [61:0]    fr;
  logic [61:0]    fden;
  logic           fovf;

  ree_div #(.NW(92), .DW(62), .QB(FQB)) u_div_range (
    .clk   (clk),
    .en    (en),
    .num   (fd_num),
    .den   (fd_den),
    .quo   (fq),
    .rem   (fr),
    .den_o (fden),
    .ovf   (fovf)
  );

  // round half away from zero and saturate the range
  logic [32:0]        rq;
  logic signed [31:0] d_val;
  logic signed [31:0] d_r;

  always_comb begin
    rq = {1'b0, fq} + 33'({fr, 1'b0} >= {1'b0, fden});
    if (neg_sh[L_FDIV]) begin
      d_val = (fovf || rq > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(-rq[31:0]);
    end else begin
      d_val = (fovf || rq > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(rq[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_val;
  end

  // offsets along the look direction
  logic [63:0]        lp_prod [3];
  logic               lp_flip [3];
  logic signed [31:0] d_lp;
  logic [31:0]        dm;

  assign dm = d_r[31] ? 32'(-d_r) : 32'(d_r);

  for (genvar i = 0; i < 3; i++) begin : g_lp
    logic [31:0] um;

    assign um = ctx[L_D].dir[i][31] ? 32'(-$signed(ctx[L_D].dir[i])) : ctx[L_D].dir[i];

    always_ff @(posedge clk) begin
      if (en) begin
        lp_prod[i] <= dm * um;
        lp_flip[i] <= d_r[31] ^ ctx[L_D].dir[i][31];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_lp <= d_r;
  end

  // final point, saturation and output word
  logic signed [31:0] pt [3];

  for (genvar i = 0; i < 3; i++) begin : g_pt
    logic [64:0]        rnd;
    logic signed [36:0] off;
    logic signed [36:0] s;

    always_comb begin
      rnd = {1'b0, lp_prod[i]} + 65'(1 << 29);
      off = $signed({2'b00, rnd[64:30]});
      s   = 37'($signed(ctx[L_LP].pos[i])) + (lp_flip[i] ? -off : off);
      if (s > 37'sh0_7FFF_FFFF) begin
        pt[i] = 32'sh7FFF_FFFF;
      end else if (s < -37'sh0_8000_0000) begin
        pt[i] = 32'sh8000_0000;
      end else begin
        pt[i] = s[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= ctx[L_LP].st;
      if (ctx[L_LP].st == ree_pkg::ST_OK) begin
        slant_range <= d_lp;
        look_x      <= pt[0];
        look_y      <= pt[1];
        look_z      <= pt[2];
      end else begin
        slant_range <= '0;
        look_x      <= '0;
        look_y      <= '0;
        look_z      <= '0;
      end
    end
  end

  // error words carry zero range and point
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ree_pkg::ST_OK |->
      slant_range == '0 && look_x == '0 && look_y == '0 && look_z == '0)
    else $error("error word with nonzero payload");

  // an accepted word enters the first stage
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[L_IN])
    else $error("accepted word not captured");

  // a held pipeline keeps its valid bits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during stall");

  // a word still marked ok has a nonzero quadratic coefficient
  a_coef: assert property (@(posedge clk) disable iff (rst)
    vld[L_SUM] && ctx[L_SUM].st == ree_pkg::ST_OK |-> a_sh[L_SUM] != '0)
    else $error("zero leading coefficient on ok word");

endmodule

`default_nettype wire

// ===== tb/sv/ree_checker.sv =====
// ree_checker: watches the ray and result channels of the intersection block,
// predicts each result word and compares it; depends on ree_pkg
`default_nettype none

module ree_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ree_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [ree_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic signed [ree_pkg::POS_W-1:0]  pos_x,
  input  wire logic signed [ree_pkg::POS_W-1:0]  pos_y,
  input  wire logic signed [ree_pkg::POS_W-1:0]  pos_z,
  input  wire logic signed [ree_pkg::DIR_W-1:0]  dir_x,
  input  wire logic signed [ree_pkg::DIR_W-1:0]  dir_y,
  input  wire logic signed [ree_pkg::DIR_W-1:0]  dir_z,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic [1:0]                        status,
  input  wire logic signed [ree_pkg::OUT_W-1:0]  slant_range,
  input  wire logic signed [ree_pkg::OUT_W-1:0]  look_x,
  input  wire logic signed [ree_pkg::OUT_W-1:0]  look_y,
  input  wire logic signed [ree_pkg::OUT_W-1:0]  look_z,
  output int                                     errors,
  output int                                     pending
);

  typedef struct {
    ree_pkg::status_t   st;
    logic signed [31:0] rng;
    logic signed [31:0] pt [3];
  } hit_t;

  logic [ree_pkg::AXIS_W-1:0] axis [3];
  logic [ree_pkg::THR_W-1:0]  thresh;
  hit_t                       hit_q [$];

  // round(|num| * 2^sh / den) half away from zero, clamped to 2^30
  function automatic longint scale_axis(longint num, int sh, longint unsigned den);
    longint unsigned m, q;
    m = (num < 0 ? -num : num) << sh;
    q = (2 * m + den) / (2 * den);
    if (q > (64'd1 << 30)) q = 64'd1 << 30;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic hit_t intersect_ray(longint p [3], longint u [3]);
    hit_t                    h;
    longint                  s [3], v [3], hh, cc, d, off;
    longint unsigned         a, ssum, prod;
    logic signed [129:0]     disc, hr;
    logic [63:0]             root, cand;
    logic [127:0]            num, quo, rem, tmag;
    logic                    neg;
    h.st = ree_pkg::ST_OK;
    h.rng = 0;
    for (int i = 0; i < 3; i++) h.pt[i] = 0;
    // tiny direction check comes first
    if ((u[0] < 0 ? -u[0] : u[0]) + (u[1] < 0 ? -u[1] : u[1]) +
        (u[2] < 0 ? -u[2] : u[2]) < longint'(thresh)) begin
      h.st = ree_pkg::ST_ZERO;
      return h;
    end
    if (axis[0] == 0 || axis[1] == 0 || axis[2] == 0) begin
      h.st = ree_pkg::ST_MISS;
      return h;
    end
    a = 0; hh = 0; ssum = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = scale_axis(p[i], 28, axis[i]);
      v[i] = scale_axis(u[i], 26, axis[i]);
      a += v[i] * v[i];
      hh += s[i] * v[i];
      ssum += s[i] * s[i];
    end
    cc = longint'(ssum) - (64'sd1 <<< 56);
    if (a == 0) begin
      h.st = ree_pkg::ST_MISS;
      return h;
    end
    disc = 130'(hh) * 130'(hh) - 130'(signed'({1'b0, a})) * 130'(cc);
    if (disc < 0) begin
      h.st = ree_pkg::ST_MISS;
      return h;
    end
    // floor square root, bit by bit
    root = 0;
    for (int b = 62; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({66'd0, cand} * {66'd0, cand} <= disc) root = cand;
    end
    hr = 130'(hh) + 130'(signed'({1'b0, root}));
    neg = (hr >= 0);
    tmag = neg ? 128'(hr) : 128'(-hr);
    num = tmag << 28;
    quo = num / a;
    rem = num % a;
    if (2 * rem >= a) quo += 1;
    if (neg) d = (quo > (128'd1 << 31)) ? -64'sd2147483648 : -longint'(quo);
    else d = (quo > 128'd2147483647) ? 64'sd2147483647 : longint'(quo);
    h.rng = d[31:0];
    for (int i = 0; i < 3; i++) begin
      prod = longint'(d < 0 ? -d : d) * longint'(u[i] < 0 ? -u[i] : u[i]);
      off = longint'((prod + (64'd1 << 29)) >> 30);
      if ((d < 0) != (u[i] < 0)) off = -off;
      off = p[i] + off;
      if (off > 64'sd2147483647) off = 64'sd2147483647;
      if (off < -64'sd2147483648) off = -64'sd2147483648;
      h.pt[i] = off[31:0];
    end
    return h;
  endfunction

  always @(posedge clk) begin
    hit_t   exp_w;
    longint p [3], u [3];
    if (rst) begin
      axis[0] = ree_pkg::AXIS_X_RST;
      axis[1] = ree_pkg::AXIS_Y_RST;
      axis[2] = ree_pkg::AXIS_Z_RST;
      thresh  = ree_pkg::THRESH_RST;
      hit_q.delete();
      errors  = 0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          ree_pkg::REG_AXIS_X: axis[0] = cfg_data[ree_pkg::AXIS_W-1:0];
          ree_pkg::REG_AXIS_Y: axis[1] = cfg_data[ree_pkg::AXIS_W-1:0];
          ree_pkg::REG_AXIS_Z: axis[2] = cfg_data[ree_pkg::AXIS_W-1:0];
          ree_pkg::REG_THRESH: thresh = cfg_data[ree_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      // accepted ray word
      if (in_valid && in_ready) begin
        p[0] = pos_x; p[1] = pos_y; p[2] = pos_z;
        u[0] = dir_x; u[1] = dir_y; u[2] = dir_z;
        hit_q.push_back(intersect_ray(p, u));
      end
      // accepted result word
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected result word exp none got status=%0d", $time, status);
          errors++;
        end else begin
          exp_w = hit_q.pop_front();
          if (status !== exp_w.st) begin
            $display("%0t: status exp %0d got %0d", $time, exp_w.st, status);
            errors++;
          end
          if (slant_range !== exp_w.rng) begin
            $display("%0t: slant_range exp %0d got %0d", $time, exp_w.rng, slant_range);
            errors++;
          end
          if (look_x !== exp_w.pt[0]) begin
            $display("%0t: look_x exp %0d got %0d", $time, exp_w.pt[0], look_x);
            errors++;
          end
          if (look_y !== exp_w.pt[1]) begin
            $display("%0t: look_y exp %0d got %0d", $time, exp_w.pt[1], look_y);
            errors++;
          end
          if (look_z !== exp_w.pt[2]) begin
            $display("%0t: look_z exp %0d got %0d", $time, exp_w.pt[2], look_z);
            errors++;
          end
        end
      end
    end
    pending = hit_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_ray_ellipsoid_intersect_top.sv =====
// tb_ray_ellipsoid_intersect_top: ray stimulus, config phases and verdict
// depends on ree_pkg, ray_ellipsoid_intersect_top and ree_checker
`default_nettype none

module tb_ray_ellipsoid_intersect_top;

  localparam int DRAIN_CYC = 160;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [ree_pkg::IDX_W-1:0] cfg_index = '0;
  logic [ree_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ree_pkg::POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [ree_pkg::DIR_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [ree_pkg::OUT_W-1:0] slant_range, look_x, look_y, look_z;
  int errors, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  ray_ellipsoid_intersect_top i_dut (.*);

  ree_checker i_chk (.*);

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_ray(longint px, longint py, longint pz,
                          longint ux, longint uy, longint uz);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= 29'(px); pos_y <= 29'(py); pos_z <= 29'(pz);
    dir_x <= 32'(ux); dir_y <= 32'(uy); dir_z <= 32'(uz);
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // wait until every result word is back, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_regs(longint ax, longint ay, longint az, longint thr);
    cfg_wr_en <= 1'b1; cfg_index <= ree_pkg::REG_AXIS_X; cfg_data <= 27'(ax);
    @(posedge clk);
    cfg_index <= ree_pkg::REG_AXIS_Y; cfg_data <= 27'(ay);
    @(posedge clk);
    cfg_index <= ree_pkg::REG_AXIS_Z; cfg_data <= 27'(az);
    @(posedge clk);
    cfg_index <= ree_pkg::REG_THRESH; cfg_data <= 27'(thr);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // mostly rays aimed near the center from a random point, some noise
  task automatic random_ray();
    longint p [3], u [3];
    real    w [3], len;
    int     kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++)
      p[i] = longint'($urandom_range(320000000)) - 160000000;
    if (kind < 70) begin
      for (int i = 0; i < 3; i++)
        w[i] = -real'(p[i]) + (real'($urandom_range(80000000)) - 40000000.0);
      len = $sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]) + 1.0;
      for (int i = 0; i < 3; i++) u[i] = longint'(w[i] / len * 1073741824.0);
    end else if (kind < 90) begin
      for (int i = 0; i < 3; i++)
        u[i] = longint'($urandom_range(32'h8000_0000)) - 1073741824;
    end else begin
      for (int i = 0; i < 3; i++)
        u[i] = longint'($urandom_range(4000)) - 2000;
    end
    send_ray(p[0], p[1], p[2], u[0], u[1], u[2]);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  initial begin
    longint axl, axh;
    axl = 101680000;
    axh = 102240000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words on reset config
    set_idling(3);
    send_ray(160000000, 0, 0, -1073741824, 0, 0);
    send_ray(-160000000, 0, 0, 1073741824, 0, 0);
    send_ray(0, 160000000, 0, 0, -1073741824, 0);
    send_ray(0, 0, -160000000, 0, 0, 1073741824);
    send_ray(0, 0, 0, 1073741824, 0, 0);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(160000000, 160000000, 160000000, 1073741824, 0, 0);
    send_ray(160000000, 0, 0, 1, 0, 0);
    send_ray(160000000, 0, 0, -64, 0, 0);
    send_ray(-160000000, -160000000, -160000000, 619925131, 619925131, 619925131);
    send_ray(110000000, 0, 0, 0, 1073741824, 0);
    send_ray(50000000, -20000000, 10000000, -1073741824, -1073741824, -1073741824);
    drain();

    // tiny directions against the threshold, then a zero semi-axis and extreme semi-axes
    write_regs(axl, axl, axl, 0);
    send_ray(160000000, 0, 0, 1, 0, 0);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(-160000000, 0, 0, 300, -5, 7);
    drain();
    write_regs(axh, axh, axh, 1048576);
    send_ray(160000000, 0, 0, -1048575, 0, 0);
    send_ray(160000000, 0, 0, -1048576, 0, 0);
    send_ray(160000000, 0, 0, -1073741824, 0, 0);
    drain();
    write_regs(0, axh, axh, 1);
    send_ray(160000000, 0, 0, -1073741824, 0, 0);
    send_ray(0, 0, 0, 0, 0, 0);
    drain();
    write_regs(134217727, 1, 134217727, 2097151);
    send_ray(160000000, 0, 0, -1073741824, 0, 0);
    send_ray(0, 0, 0, 0, 1073741824, 0);
    drain();

    // random phases across settings and idling modes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_regs(ree_pkg::AXIS_X_RST, ree_pkg::AXIS_Y_RST, ree_pkg::AXIS_Z_RST,
                      ree_pkg::THRESH_RST);
        1: write_regs(axl, axl, axl, 0);
        2: write_regs(axh, axh, axh, 1048576);
        3: write_regs(axh, axl, axl, $urandom_range(2000));
        default: write_regs($urandom_range(axh, axl), $urandom_range(axh, axl),
                            $urandom_range(axh, axl), $urandom_range(4096));
      endcase
      for (int k = 0; k < 240; k++) begin
        if (k % 60 == 0) set_idling(ph + k / 60);
        random_ray();
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== ray_ellipsoid_intersect_top.f =====
rtl/ree_pkg.sv
rtl/ree_div.sv
rtl/ray_ellipsoid_intersect_top.sv
tb/sv/ree_checker.sv
tb/sv/tb_ray_ellipsoid_intersect_top.sv
